// ----- rtl/ihx_pkg.sv -----
package ihx_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 1;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_COUNT   = 3'd1,
        PH_ADDR_HI = 3'd2,
        PH_ADDR_LO = 3'd3,
        PH_TYPE    = 3'd4,
        PH_DATA    = 3'd5,
        PH_CSUM    = 3'd6,
        PH_TAIL    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_COLON  = 3'd1,
        ST_BAD_HEX   = 3'd2,
        ST_SHORT     = 3'd3,
        ST_CSUM_FAIL = 3'd4
    } status_t;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    // one result item as it leaves the parse core
    typedef struct packed {
        kind_t       kind;
        logic [15:0] byte_address;
        logic [7:0]  data_byte;
        logic [7:0]  record_type;
        status_t     status;
        logic        ignoring;
    } result_t;

    // {valid, value} of one ascii hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ----- rtl/ihx_parse_core.sv -----
module ihx_parse_core
    import ihx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  char_in,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic        pending_reg, pending_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seen_reg, seen_next;
    logic [7:0]  sum_reg, sum_next;
    logic        nonzero_reg, nonzero_next;
    logic        ignore_reg, ignore_next;
    status_t     err_reg, err_next;
    logic        halted_reg, halted_next;

    logic [4:0]  hex;
    logic [7:0]  byte_val;
    logic [7:0]  sum_add;
    logic [7:0]  seen_inc;
    status_t     end_status;

    assign hex      = hex_decode(char_in);
    assign byte_val = {high_nibble_reg, hex[3:0]};
    assign sum_add  = sum_reg + byte_val;
    assign seen_inc = seen_reg + 8'd1;

    always_comb begin
        if (err_reg != ST_OK) begin
            end_status = err_reg;
        end else if (phase_reg == PH_START) begin
            end_status = ST_NO_COLON;
        end else if (phase_reg != PH_TAIL) begin
            end_status = ST_SHORT;
        end else begin
            end_status = ST_OK;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        pending_next     = pending_reg;
        count_next       = count_reg;
        addr_next        = addr_reg;
        type_next        = type_reg;
        seen_next        = seen_reg;
        sum_next         = sum_reg;
        nonzero_next     = nonzero_reg;
        ignore_next      = ignore_reg;
        err_next         = err_reg;
        halted_next      = halted_reg;

        res_valid        = 1'b0;
        res.kind         = KIND_DATA;
        res.byte_address = addr_reg + 16'(seen_reg);
        res.data_byte    = byte_val;
        res.record_type  = type_reg;
        res.status       = ST_OK;
        res.ignoring     = ignore_reg;

        if (step && !halted_reg && char_in != CHAR_CR) begin
            if (char_in == CHAR_LF) begin
                // end of line: report, then start a fresh line
                if (end_status == ST_OK && type_reg == REC_EXT_LIN) begin
                    ignore_next = nonzero_reg;
                end
                res_valid        = 1'b1;
                res.kind         = KIND_END;
                res.byte_address = addr_reg;
                res.data_byte    = 8'd0;
                res.status       = end_status;
                res.ignoring     = (end_status == ST_OK && type_reg == REC_EXT_LIN)
                                   ? nonzero_reg : ignore_reg;
                if (end_status != ST_OK) begin
                    halted_next = 1'b1;
                end
                phase_next       = PH_START;
                high_nibble_next = 4'd0;
                pending_next     = 1'b0;
                count_next       = 8'd0;
                addr_next        = 16'd0;
                type_next        = 8'd0;
                seen_next        = 8'd0;
                sum_next         = 8'd0;
                nonzero_next     = 1'b0;
                err_next         = ST_OK;
            end else if (err_reg == ST_OK && phase_reg != PH_TAIL) begin
                if (phase_reg == PH_START) begin
                    if (char_in == CHAR_COLON) begin
                        phase_next = PH_COUNT;
                    end else begin
                        err_next = ST_NO_COLON;
                    end
                end else if (!hex[4]) begin
                    err_next = ST_BAD_HEX;
                end else if (!pending_reg) begin
                    high_nibble_next = hex[3:0];
                    pending_next     = 1'b1;
                end else begin
                    pending_next = 1'b0;
                    case (phase_reg)
                        PH_COUNT: begin
                            count_next = byte_val;
                            sum_next   = sum_add;
                            phase_next = PH_ADDR_HI;
                        end
                        PH_ADDR_HI: begin
                            addr_next  = {byte_val, 8'd0};
                            sum_next   = sum_add;
                            phase_next = PH_ADDR_LO;
                        end
                        PH_ADDR_LO: begin
                            addr_next  = {addr_reg[15:8], byte_val};
                            sum_next   = sum_add;
                            phase_next = PH_TYPE;
                        end
                        PH_TYPE: begin
                            type_next  = byte_val;
                            sum_next   = sum_add;
                            phase_next = (count_reg == 8'd0) ? PH_CSUM : PH_DATA;
                        end
                        PH_DATA: begin
                            sum_next = sum_add;
                            if (byte_val != 8'd0) begin
                                nonzero_next = 1'b1;
                            end
                            if (type_reg == REC_DATA && !ignore_reg) begin
                                res_valid = 1'b1;
                            end
                            seen_next = seen_inc;
                            if (seen_inc == count_reg) begin
                                phase_next = PH_CSUM;
                            end
                        end
                        PH_CSUM: begin
                            if (sum_add != 8'd0) begin
                                err_next = ST_CSUM_FAIL;
                            end
                            phase_next = PH_TAIL;
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_START;
            high_nibble_reg <= 4'd0;
            pending_reg     <= 1'b0;
            count_reg       <= 8'd0;
            addr_reg        <= 16'd0;
            type_reg        <= 8'd0;
            seen_reg        <= 8'd0;
            sum_reg         <= 8'd0;
            nonzero_reg     <= 1'b0;
            ignore_reg      <= 1'b0;
            err_reg         <= ST_OK;
            halted_reg      <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            pending_reg     <= pending_next;
            count_reg       <= count_next;
            addr_reg        <= addr_next;
            type_reg        <= type_next;
            seen_reg        <= seen_next;
            sum_reg         <= sum_next;
            nonzero_reg     <= nonzero_next;
            ignore_reg      <= ignore_next;
            err_reg         <= err_next;
            halted_reg      <= halted_next;
        end
    end

endmodule

// ----- rtl/intel_hex_record_parser.sv -----
// channel | dir | tdata (lsb first)                                | tuser
// s_      | in  | character[7:0]                                   | -
// m_      | out | byte_address[15:0] data_byte[23:16]              | kind[0]
//         |     | record_type[31:24] status[34:32] ignoring[35]    |
//         |     | zero[39:36]                                      |
//
// one character item per cycle while the m_ side does not stall; each character
// passes from the input register through the parse core into the result register
// at most one result item per character; cr and chars after the checksum
// give none, and after a failed line nothing is produced until reset
// aresetn is synchronous active low and clears all line and mode state
// a stalled m_ side holds the result and one more item waits in the input
// register before s_tready drops
module intel_hex_record_parser
    import ihx_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // character[7:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // byte_address, data_byte, record_type,
                                             // status, ignoring, zero fill
    output logic [OUT_USER_W-1:0] m_tuser    // kind
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_char_reg;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_res_reg;
    logic                 advance;
    logic                 s_take;
    logic                 res_valid;
    result_t              res;

    // result register is free or being drained this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg && res_valid;
        end
    end

    ihx_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_valid_reg && advance),
        .char_in   (in_char_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_char_reg <= s_tdata;
        end
        if (advance && in_valid_reg && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.ignoring, out_res_reg.status,
                       out_res_reg.record_type, out_res_reg.data_byte,
                       out_res_reg.byte_address};
    assign m_tuser  = out_res_reg.kind;

endmodule
